FILE: design/lrg_pkg.sv
`timescale 1ns / 1ps

package lrg_pkg;

   localparam int LEVEL_BITS_DEF    = 32;
   localparam int DURATION_BITS_DEF = 24;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_RETARGET = 2'd1,
      OP_PRESET   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic mul;
      logic div_init;
      logic div;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic mul_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

FILE: design/lrg_ctrl.sv
`timescale 1ns / 1ps

module lrg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_op,
   output logic                req_ready,
   input  lrg_pkg::status_type status,
   output lrg_pkg::cmd_type    cmd
);
   import lrg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_op == OP_TICK) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.len_zero ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            if (status.mul_last) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait here while an earlier sample sits in the output register and the receiver is not ready.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !status.out_free) |=> state_ff == ST_FINISH)
      else $error("finish left while output register was occupied");
   a_div_after_init: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_INIT |=> state_ff == ST_DIV)
      else $error("divide did not follow its initialization");
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_op == OP_TICK) |=> state_ff == ST_PREP)
      else $error("accepted tick did not start the datapath");
`endif

endmodule

FILE: design/lrg_dp.sv
`timescale 1ns / 1ps

module lrg_dp #(
   parameter int LEVEL_BITS    = lrg_pkg::LEVEL_BITS_DEF,
   parameter int DURATION_BITS = lrg_pkg::DURATION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_op,
   input  logic signed [LEVEL_BITS-1:0] req_target_level,
   input  logic [DURATION_BITS-1:0]     req_duration_samples,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [LEVEL_BITS-1:0] rsp_level,
   input  lrg_pkg::cmd_type             cmd,
   output lrg_pkg::status_type          status
);
   import lrg_pkg::*;

   localparam int LW = LEVEL_BITS;
   localparam int DW = DURATION_BITS;
   localparam int MW = LW + 1;
   localparam int PW = MW + DW;
   localparam int CW = $clog2((MW > DW) ? MW : DW);

   logic signed [LW-1:0] start_ff, start_in;
   logic signed [LW-1:0] goal_ff, goal_in;
   logic signed [LW-1:0] current_ff, current_in;
   logic [DW-1:0]        step_ff, step_in;
   logic [DW-1:0]        len_ff, len_in;

   logic                 neg_ff, neg_in;
   logic [PW-1:0]        mcand_ff, mcand_in;
   logic [DW-1:0]        mplier_ff, mplier_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [MW-1:0]        quo_ff, quo_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [LW-1:0] rsp_level_ff, rsp_level_in;

   logic signed [LW:0]   diff;
   logic [MW-1:0]        mag;
   logic [DW:0]          shifted;
   logic [DW+1:0]        trial;
   logic                 fits;
   logic signed [LW:0]   ramp_sum;
   logic signed [LW-1:0] result;

   assign diff    = {goal_ff[LW-1], goal_ff} - {start_ff[LW-1], start_ff};
   assign mag     = diff[LW] ? MW'(-diff) : MW'(diff);
   assign shifted = {rem_ff, quo_ff[MW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, len_ff};
   assign fits    = !trial[DW+1];

   // The quotient never exceeds the magnitude, so the level stays between start and goal.
   assign ramp_sum = neg_ff ? ({start_ff[LW-1], start_ff} - $signed(quo_ff))
                            : ({start_ff[LW-1], start_ff} + $signed(quo_ff));
   assign result   = (len_ff == '0) ? start_ff : ramp_sum[LW-1:0];

   assign status.len_zero = (len_ff == '0);
   assign status.mul_last = (cnt_ff == CW'(DW - 1));
   assign status.div_last = (cnt_ff == CW'(MW - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   always_comb begin
      start_in     = start_ff;
      goal_in      = goal_ff;
      current_in   = current_ff;
      step_in      = step_ff;
      len_in       = len_ff;
      neg_in       = neg_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.accept) begin
         unique case (req_op)
            OP_PRESET: begin
               start_in   = req_target_level;
               goal_in    = req_target_level;
               current_in = req_target_level;
               step_in    = '0;
               len_in     = '0;
            end
            OP_RETARGET: begin
               goal_in  = req_target_level;
               len_in   = req_duration_samples;
               start_in = current_ff;
               step_in  = '0;
            end
            OP_TICK: begin
               if (len_ff != '0) begin
                  if (step_ff == len_ff) begin
                     step_in  = '0;
                     len_in   = '0;
                     start_in = goal_ff;
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.prep) begin
         neg_in    = diff[LW];
         mcand_in  = {{DW{1'b0}}, mag};
         mplier_in = step_ff;
         prod_in   = '0;
         cnt_in    = '0;
      end

      // Shift-add multiply: one bit of the step count per cycle.
      if (cmd.mul) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PW-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[DW-1:1]};
         cnt_in    = cnt_ff + 1'b1;
      end

      // The upper part of the product is already below the length, so only
      // the low bits produce quotient bits.
      if (cmd.div_init) begin
         rem_in = prod_ff[PW-1:MW];
         quo_in = prod_ff[MW-1:0];
         cnt_in = '0;
      end

      if (cmd.div) begin
         rem_in = fits ? trial[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[MW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.finish) begin
         current_in   = result;
         rsp_level_in = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         goal_ff      <= '0;
         current_ff   <= '0;
         step_ff      <= '0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         current_ff   <= current_in;
         step_ff      <= step_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_level_ff <= rsp_level_in;
   end

`ifndef SYNTHESIS
   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      step_ff <= len_ff)
      else $error("step count ran past the ramp length");
   a_preset_idles: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_op == OP_PRESET) |=> (len_ff == '0 && step_ff == '0))
      else $error("preset left a ramp running");
   a_quo_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && len_ff != '0) |-> quo_ff <= mcand_ff[MW-1:0] || quo_ff <= mag)
      else $error("interpolation quotient exceeds the ramp span");
`endif

endmodule

FILE: design/linear_ramp_generator_unit.sv
`timescale 1ns / 1ps

// Linear ramp generator: signed Q16.16 glide from the last output level to a target.
// Request channel (req_valid/req_ready) carries one beat per operation:
//   tick gives one sample on the response channel, retarget starts a ramp from the
//   current level over req_duration_samples ticks, preset jumps to a level at once.
//   Retarget and preset give no response beat; an unused op code is dropped.
// Response channel (rsp_valid/rsp_level/rsp_ready) carries one beat per tick.
// A tick runs through a shift-add multiplier (one step bit per cycle) and a
// restoring divider (one quotient bit per cycle). The block handles one
// request at a time and takes no new request until the last one is done.
// A zero-length ramp skips the arithmetic.
// The output register holds one sample: the next request is taken while it
// waits, and a tick that finishes while the receiver stalls waits for it.
// Synchronous reset zeroes the start, goal and current levels, the step count
// and the ramp length.
module linear_ramp_generator_unit #(
   parameter int LEVEL_BITS    = lrg_pkg::LEVEL_BITS_DEF,
   parameter int DURATION_BITS = lrg_pkg::DURATION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic signed [LEVEL_BITS-1:0] req_target_level,
   input  logic [DURATION_BITS-1:0]     req_duration_samples,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [LEVEL_BITS-1:0] rsp_level
);
   import lrg_pkg::*;

   cmd_type    cmd;
   status_type status;

   lrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrg_dp #(
      .LEVEL_BITS    (LEVEL_BITS),
      .DURATION_BITS (DURATION_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_op               (req_op),
      .req_target_level     (req_target_level),
      .req_duration_samples (req_duration_samples),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_level            (rsp_level),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule
